// ===== sv/iso8211_record_deframer_unit_assert.svh =====
// Assertion macros used by the deframer top module.
`ifndef ISO8211_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define ISO8211_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define I8RD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication under reset.
`define I8RD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== sv/i8rd_pkg.sv =====
package i8rd_pkg;

  localparam int LEADER_BYTES  = 24;
  localparam int TAG_MAX_CHARS = 8;

  localparam logic [7:0] FIELD_TERM = 8'h1E;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [2:0] KIND_LEADER = 3'd0;
  localparam logic [2:0] KIND_ENTRY  = 3'd1;
  localparam logic [2:0] KIND_FIELD  = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_FIRST_NOTL = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_TOO_SMALL  = 3'd4;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] entry_tag;
    logic [29:0] number_a;
    logic [29:0] number_b;
    logic [7:0]  leader_kind;
    logic [6:0]  control_length;
    logic [3:0]  length_size;
    logic [3:0]  position_size;
    logic [3:0]  tag_size;
    logic [7:0]  byte_out;
    logic [2:0]  status;
    logic        last_of_item;
  } i8rd_result_t;

  typedef struct packed {
    logic [1:0]   count;
    i8rd_result_t r0;
    i8rd_result_t r1;
  } i8rd_push_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CHAR_0) && (b <= CHAR_9);
  endfunction

  function automatic logic [29:0] acc_digit(logic [29:0] acc, logic [7:0] b);
    logic [7:0] d;
    d = b - CHAR_0;
    if (is_digit(b)) begin
      return (acc << 3) + (acc << 1) + {22'b0, d};
    end
    return acc;
  endfunction

  function automatic logic [3:0] one_digit(logic [7:0] b);
    logic [7:0] d;
    d = b - CHAR_0;
    return is_digit(b) ? d[3:0] : 4'd0;
  endfunction

  function automatic i8rd_result_t new_result(logic [2:0] kind);
    i8rd_result_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

endpackage

// ===== sv/i8rd_in_if.sv =====
interface i8rd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== sv/i8rd_out_if.sv =====
interface i8rd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] entry_tag;
  logic [29:0] number_a;
  logic [29:0] number_b;
  logic [7:0]  leader_kind;
  logic [6:0]  control_length;
  logic [3:0]  length_size;
  logic [3:0]  position_size;
  logic [3:0]  tag_size;
  logic [7:0]  byte_out;
  logic [2:0]  status;
  logic        last_of_item;

  modport source (
    output valid, output kind, output entry_tag, output number_a, output number_b,
    output leader_kind, output control_length, output length_size,
    output position_size, output tag_size, output byte_out, output status,
    output last_of_item, input ready
  );
  modport sink (
    input valid, input kind, input entry_tag, input number_a, input number_b,
    input leader_kind, input control_length, input length_size,
    input position_size, input tag_size, input byte_out, input status,
    input last_of_item, output ready
  );
endinterface

// ===== sv/i8rd_parser.sv =====
module i8rd_parser (
  input  logic               clk,
  input  logic               rst,
  i8rd_in_if.sink            in_ch,
  input  logic               room,
  output i8rd_pkg::i8rd_push_t push
);
  import i8rd_pkg::*;

  localparam logic PH_LEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_eod;
  logic       fire;

  logic        phase, phase_next;
  logic [16:0] rbi, rbi_next;
  logic [16:0] rlen, rlen_next;
  logic [16:0] base, base_next;
  logic [6:0]  fcl, fcl_next;
  logic [3:0]  ld, ld_next;
  logic [3:0]  pd, pd_next;
  logic [3:0]  tc, tc_next;
  logic [7:0]  lid, lid_next;
  logic [4:0]  ebi, ebi_next;
  logic [63:0] tag, tag_next;
  logic [29:0] lacc, lacc_next;
  logic [29:0] pacc, pacc_next;
  logic [15:0] rseen, rseen_next;
  logic        stopped, stopped_next;
  logic        dclosed, dclosed_next;

  assign fire = s_valid && room;
  assign in_ch.ready = !s_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s_byte <= in_ch.data_byte;
      s_eod  <= in_ch.end_of_data;
    end
  end

  always_comb begin
    i8rd_result_t rr [2];
    i8rd_result_t x;
    logic [1:0]  n;
    logic [29:0] t30;
    logic [5:0]  esize;
    logic [5:0]  kk;
    logic [5:0]  tl;
    logic [29:0] start;
    logic [29:0] rlen30;
    logic [29:0] len;
    logic [16:0] i_inc;

    phase_next = phase;  rbi_next = rbi;   rlen_next = rlen;   base_next = base;
    fcl_next = fcl;      ld_next = ld;     pd_next = pd;       tc_next = tc;
    lid_next = lid;      ebi_next = ebi;   tag_next = tag;     lacc_next = lacc;
    pacc_next = pacc;    rseen_next = rseen;
    stopped_next = stopped;
    dclosed_next = dclosed;
    rr[0] = '0;
    rr[1] = '0;
    n = 2'd0;
    x = '0;
    t30 = '0;
    esize = '0;
    kk = '0;
    tl = '0;
    start = '0;
    rlen30 = '0;
    len = '0;
    i_inc = '0;

    if (fire) begin
      if (!stopped) begin
        if (phase == PH_LEADER) begin
          if (rbi == 17'd0) begin
            rlen_next = '0; base_next = '0; fcl_next = '0; lid_next = '0;
            ld_next = '0;   pd_next = '0;   tc_next = '0;
          end
          if (rbi < 17'd5) begin
            t30 = acc_digit({13'b0, rlen_next}, s_byte);
            rlen_next = t30[16:0];
          end else if (rbi == 17'd6) begin
            lid_next = s_byte;
          end else if (rbi == 17'd10 || rbi == 17'd11) begin
            t30 = acc_digit({23'b0, fcl_next}, s_byte);
            fcl_next = t30[6:0];
          end else if (rbi >= 17'd12 && rbi <= 17'd16) begin
            t30 = acc_digit({13'b0, base_next}, s_byte);
            base_next = t30[16:0];
          end else if (rbi == 17'd20) begin
            ld_next = one_digit(s_byte);
          end else if (rbi == 17'd21) begin
            pd_next = one_digit(s_byte);
          end else if (rbi == 17'd23) begin
            tc_next = one_digit(s_byte);
          end

          if (rbi < 17'(LEADER_BYTES - 1)) begin
            rbi_next = rbi + 17'd1;
            if (s_eod) begin
              x = new_result(KIND_ERROR);
              x.number_a = {14'b0, rseen};
              x.status = (rseen == 16'd0) ? ST_TOO_SMALL : ST_TRUNCATED;
              rr[n[0]] = x; n = n + 2'd1;
              stopped_next = 1'b1;
            end
          end else begin
            x = new_result(KIND_LEADER);
            x.number_a = {13'b0, rlen_next};
            x.number_b = {13'b0, base_next};
            x.leader_kind = lid_next;
            x.control_length = fcl_next;
            x.length_size = ld_next;
            x.position_size = pd_next;
            x.tag_size = tc_next;
            rr[n[0]] = x; n = n + 2'd1;
            x = new_result(KIND_ERROR);
            x.number_a = {14'b0, rseen};
            if (rlen_next < 17'(LEADER_BYTES)) begin
              x.status = ST_BAD_LENGTH;
              rr[n[0]] = x; n = n + 2'd1;
              stopped_next = 1'b1;
            end else if (s_eod && rlen_next > 17'(LEADER_BYTES)) begin
              x.status = ST_TRUNCATED;
              rr[n[0]] = x; n = n + 2'd1;
              stopped_next = 1'b1;
            end else if (rseen == 16'd0 && lid_next != CHAR_L) begin
              x.status = ST_FIRST_NOTL;
              rr[n[0]] = x; n = n + 2'd1;
              stopped_next = 1'b1;
            end else if (rlen_next == 17'(LEADER_BYTES)) begin
              rseen_next = rseen + 16'd1;
              x = new_result(KIND_END);
              x.number_a = {14'b0, rseen_next};
              rr[n[0]] = x; n = n + 2'd1;
              rbi_next = '0;
            end else begin
              if (base_next > rlen_next) begin
                base_next = rlen_next;
              end
              dclosed_next = ({2'b0, tc_next} + {2'b0, ld_next} + {2'b0, pd_next}) == 6'd0;
              ebi_next = '0;
              rbi_next = 17'(LEADER_BYTES);
              phase_next = PH_BODY;
            end
          end
        end else begin
          esize = {2'b0, tc} + {2'b0, ld} + {2'b0, pd};
          if (rbi >= base) begin
            x = new_result(KIND_FIELD);
            x.number_a = {13'b0, rbi - base};
            x.byte_out = s_byte;
            rr[n[0]] = x; n = n + 2'd1;
          end else if (!dclosed) begin
            if (ebi == 5'd0 && (s_byte == FIELD_TERM ||
                ({1'b0, rbi} + {12'b0, esize}) > {1'b0, base})) begin
              dclosed_next = 1'b1;
            end else begin
              if (ebi == 5'd0) begin
                tag_next = '0; lacc_next = '0; pacc_next = '0;
              end
              kk = {1'b0, ebi};
              tl = {2'b0, tc} + {2'b0, ld};
              if (kk < {2'b0, tc}) begin
                if (kk < 6'(TAG_MAX_CHARS)) begin
                  tag_next = {tag_next[55:0], s_byte};
                end
              end else if (kk < tl) begin
                lacc_next = acc_digit(lacc_next, s_byte);
              end else begin
                pacc_next = acc_digit(pacc_next, s_byte);
              end
              kk = kk + 6'd1;
              if (kk >= esize) begin
                rlen30 = {13'b0, rlen};
                start = {13'b0, base} + pacc_next;
                if (start >= rlen30) begin
                  len = '0;
                end else if (lacc_next > rlen30 - start) begin
                  len = rlen30 - start;
                end else begin
                  len = lacc_next;
                end
                x = new_result(KIND_ENTRY);
                x.entry_tag = tag_next;
                x.number_a = start;
                x.number_b = len;
                rr[n[0]] = x; n = n + 2'd1;
                ebi_next = '0;
              end else begin
                ebi_next = kk[4:0];
              end
            end
          end
          i_inc = rbi + 17'd1;
          if (i_inc >= rlen) begin
            rseen_next = rseen + 16'd1;
            x = new_result(KIND_END);
            x.number_a = {14'b0, rseen_next};
            rr[n[0]] = x; n = n + 2'd1;
            rbi_next = '0;
            phase_next = PH_LEADER;
          end else begin
            rbi_next = i_inc;
            if (s_eod) begin
              x = new_result(KIND_ERROR);
              x.number_a = {14'b0, rseen};
              x.status = ST_TRUNCATED;
              rr[n[0]] = x; n = n + 2'd1;
              stopped_next = 1'b1;
            end
          end
        end
      end

      if (s_eod) begin
        phase_next = PH_LEADER; rbi_next = '0;  rlen_next = '0; base_next = '0;
        fcl_next = '0;  ld_next = '0;  pd_next = '0;   tc_next = '0;
        lid_next = '0;  ebi_next = '0; tag_next = '0;  lacc_next = '0;
        pacc_next = '0; rseen_next = '0;
        stopped_next = 1'b0;
        dclosed_next = 1'b0;
      end

      if (n == 2'd1) begin
        rr[0].last_of_item = 1'b1;
      end else if (n == 2'd2) begin
        rr[1].last_of_item = 1'b1;
      end
    end

    push.count = n;
    push.r0 = rr[0];
    push.r1 = rr[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEADER; rbi <= '0;  rlen <= '0; base <= '0;
      fcl <= '0;  ld <= '0;  pd <= '0;   tc <= '0;
      lid <= '0;  ebi <= '0; tag <= '0;  lacc <= '0;
      pacc <= '0; rseen <= '0;
      stopped <= 1'b0;
      dclosed <= 1'b0;
    end else begin
      phase <= phase_next; rbi <= rbi_next;   rlen <= rlen_next; base <= base_next;
      fcl <= fcl_next;     ld <= ld_next;     pd <= pd_next;     tc <= tc_next;
      lid <= lid_next;     ebi <= ebi_next;   tag <= tag_next;   lacc <= lacc_next;
      pacc <= pacc_next;   rseen <= rseen_next;
      stopped <= stopped_next;
      dclosed <= dclosed_next;
    end
  end
endmodule

// ===== sv/i8rd_fifo.sv =====
module i8rd_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  i8rd_pkg::i8rd_push_t   push,
  input  logic                   pop,
  output i8rd_pkg::i8rd_result_t head,
  output logic                   head_valid,
  output logic                   room,
  output logic [2:0]             level
);
  import i8rd_pkg::*;

  i8rd_result_t entries [RQ_DEPTH];
  logic [RQ_AW-1:0] wp, rp;
  logic [RQ_CW-1:0] level_next;

  assign head       = entries[rp];
  assign head_valid = level != '0;
  assign room       = level <= RQ_CW'(RQ_DEPTH - 2);
  assign level_next = level + {1'b0, push.count} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wp] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wp + RQ_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + RQ_AW'(push.count);
      rp    <= rp + RQ_AW'(pop);
      level <= level_next;
    end
  end
endmodule

// ===== sv/iso8211_record_deframer_unit.sv =====
// ISO 8211 record deframer: feed the file one byte per request on in_ch and
// raise end_of_data with its last byte; results leave on out_ch one per
// request, in order (leader, directory entries, field bytes with their offset
// from the field area base, record end, or an error that silences the rest
// of the file). A byte is taken every cycle while the output keeps pace; it
// is held in the input register until the result queue has room, and its
// results are then written into the queue and offered from its head. A byte
// yields up to two results, and the output drains one per cycle, while
// out_ch.ready is high, from a four-entry result queue; a byte waits in the
// input register whenever that queue has fewer than two free entries, so
// bytes that yield two results set the long-run pace at the output side. No
// clearing pass is needed after reset.
`include "iso8211_record_deframer_unit_assert.svh"

module iso8211_record_deframer_unit (
  input logic        clk,
  input logic        rst,
  i8rd_in_if.sink    in_ch,
  i8rd_out_if.source out_ch
);
  import i8rd_pkg::*;

  i8rd_push_t   push;
  i8rd_result_t head;
  logic         head_valid;
  logic         room;
  logic [2:0]   level;
  logic         pop;

  i8rd_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  assign pop = head_valid && out_ch.ready;

  i8rd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .room       (room),
    .level      (level)
  );

  assign out_ch.valid          = head_valid;
  assign out_ch.kind           = head.kind;
  assign out_ch.entry_tag      = head.entry_tag;
  assign out_ch.number_a       = head.number_a;
  assign out_ch.number_b       = head.number_b;
  assign out_ch.leader_kind    = head.leader_kind;
  assign out_ch.control_length = head.control_length;
  assign out_ch.length_size    = head.length_size;
  assign out_ch.position_size  = head.position_size;
  assign out_ch.tag_size       = head.tag_size;
  assign out_ch.byte_out       = head.byte_out;
  assign out_ch.status         = head.status;
  assign out_ch.last_of_item   = head.last_of_item;

  `I8RD_ASSERT_NEXT(a_push_shows, clk, rst, push.count != 2'd0, out_ch.valid)
  `I8RD_ASSERT_IMPL(a_level_bound, clk, rst, 1'b1, level <= RQ_CW'(RQ_DEPTH))
  `I8RD_ASSERT_IMPL(a_last_mark, clk, rst, push.count == 2'd2, !push.r0.last_of_item && push.r1.last_of_item)
endmodule
